FILE: rtl/ptpd_pkg.sv
// Package: widths, types and helpers for the point transform / perspective divide block.
`default_nettype none
package ptpd_pkg;
    localparam int unsigned CoordW   = 32;
    localparam int unsigned CfgW     = 64;
    localparam int unsigned NumPairs = 8;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned SumW     = 50;
    localparam int unsigned DivW     = 66;
    localparam int unsigned QuotW    = 66;
    localparam int unsigned DivSteps = 2;

    localparam logic [CfgW-1:0] PairReset [NumPairs] = '{
        64'd65536, 64'd0, 64'h0001_0000_0000_0000, 64'd0,
        64'd0, 64'd65536, 64'd0, 64'h0001_0000_0000_0000
    };

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic signed [SumW-1:0]   t_sum;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   w_zero;
    } t_result;

    typedef struct packed {
        t_sum x;
        t_sum y;
        t_sum z;
        t_sum w;
    } t_hvec;

    function automatic t_sum mul_round(input t_coord a, input t_coord b);
        logic signed [63:0] p;
        logic [63:0]        mag;
        logic [47:0]        r;
        p   = 64'(signed'(a)) * 64'(signed'(b));
        mag = p[63] ? 64'(-p) : 64'(p);
        r   = 48'((mag + 64'd32768) >> 16);
        return p[63] ? -SumW'(r) : SumW'(r);
    endfunction
endpackage
`default_nettype wire

FILE: rtl/ptpd_stream_if.sv
// Interface: valid/ready stream channel with a generic payload.
`default_nettype none
interface ptpd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/ptpd_divider.sv
// Divider: pipelined restoring divide of a rounded quotient, two bits per stage.
`default_nettype none
module ptpd_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [ptpd_pkg::DivW-1:0]     i_num,
    input  wire logic [ptpd_pkg::SumW-2:0]     i_den,
    output logic      [ptpd_pkg::QuotW-1:0]    o_quot
);
    localparam int unsigned Stages = ptpd_pkg::QuotW / ptpd_pkg::DivSteps;
    localparam int unsigned DenW   = ptpd_pkg::SumW - 1;
    localparam int unsigned RemW   = DenW + 1;

    // Every numerator bit is shifted through, so the full quotient comes out;
    // the top level saturates it.
    logic [RemW-1:0]               r_rem  [Stages];
    logic [ptpd_pkg::DivW-1:0]     r_num  [Stages];
    logic [DenW-1:0]               r_den  [Stages];

    for (genvar s = 0; s < Stages; s++) begin : g_stage
        logic [RemW-1:0]           cur_rem;
        logic [ptpd_pkg::DivW-1:0] cur_num;
        logic [DenW-1:0]           cur_den;
        logic [RemW-1:0]           n_rem;
        logic [ptpd_pkg::DivW-1:0] n_num;
        logic [RemW:0]             diff;
        if (s == 0) begin : g_first
            assign cur_rem = '0;
            assign cur_num = i_num;
            assign cur_den = i_den;
        end else begin : g_next
            assign cur_rem = r_rem[s-1];
            assign cur_num = r_num[s-1];
            assign cur_den = r_den[s-1];
        end
        always_comb begin
            n_rem = cur_rem;
            n_num = cur_num;
            for (int k = 0; k < int'(ptpd_pkg::DivSteps); k++) begin
                diff = {n_rem, n_num[ptpd_pkg::DivW-1]};
                n_num = {n_num[ptpd_pkg::DivW-2:0], 1'b0};
                if (diff >= {2'b00, cur_den}) begin
                    diff = diff - {2'b00, cur_den};
                    n_num[0] = 1'b1;
                end
                n_rem = diff[RemW-1:0];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_num[s] <= n_num;
                r_den[s] <= cur_den;
            end
        end
    end

    assign o_quot = r_num[Stages-1][ptpd_pkg::QuotW-1:0];
endmodule
`default_nettype wire

FILE: rtl/ptpd_transform.sv
// Transform: matrix times point in two registered stages (products, then sums).
`default_nettype none
module ptpd_transform (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [ptpd_pkg::CfgW-1:0] i_pair [ptpd_pkg::NumPairs],
    input  wire ptpd_pkg::t_point          i_point,
    output ptpd_pkg::t_hvec                o_vec
);
    ptpd_pkg::t_sum r_prod [12];
    ptpd_pkg::t_sum r_tr   [4];
    ptpd_pkg::t_coord el [16];
    ptpd_pkg::t_sum n_sum [4];

    always_comb begin
        for (int e = 0; e < 16; e++) begin
            el[e] = (e % 2 == 1) ? i_pair[e/2][63:32] : i_pair[e/2][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                r_prod[r]   <= ptpd_pkg::mul_round(el[r], i_point.x);
                r_prod[r+4] <= ptpd_pkg::mul_round(el[r+4], i_point.y);
                r_prod[r+8] <= ptpd_pkg::mul_round(el[r+8], i_point.z);
                r_tr[r]     <= ptpd_pkg::SumW'(el[r+12]);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_sum[r] = r_prod[r] + r_prod[r+4] + r_prod[r+8] + r_tr[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_vec.x <= n_sum[0];
            o_vec.y <= n_sum[1];
            o_vec.z <= n_sum[2];
            o_vec.w <= n_sum[3];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/point_transform_perspective_divide_top.sv
// Top level: 4x4 homogeneous point transform with perspective divide.
// Pipeline: 37 register stages (2 transform, 1 prep, 33 divide, 1 output).
// Throughput: one transaction per cycle while the skid entry is empty; every stage,
// the divider's 33 included, is pipelined. A stall on the output fills the skid entry
// and then holds the whole pipeline; no item is lost or repeated.
// Reset (synchronous, active low) clears valid bits and loads the identity matrix.
`default_nettype none
module point_transform_perspective_divide_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    ptpd_stream_if.sink                        s_in,
    ptpd_stream_if.source                      m_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [ptpd_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  wire logic [ptpd_pkg::CfgW-1:0]     i_cfg_data
);
    localparam int unsigned DivStages = ptpd_pkg::QuotW / ptpd_pkg::DivSteps;
    localparam int unsigned Lat       = DivStages + 3;

    logic [ptpd_pkg::CfgW-1:0] r_pair [ptpd_pkg::NumPairs];
    logic [Lat-1:0]            r_vld;
    logic                      en;
    ptpd_pkg::t_hvec           vec;

    // Output register, with a one-entry skid stage that catches a result arriving during a stall.
    ptpd_pkg::t_result r_out, r_skid;
    logic              r_out_vld, r_skid_vld;

    assign en         = !r_skid_vld;
    assign s_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < int'(ptpd_pkg::NumPairs); k++) begin
                r_pair[k] <= ptpd_pkg::PairReset[k];
            end
        end else if (i_cfg_we) begin
            r_pair[i_cfg_idx] <= i_cfg_data;
        end
    end

    ptpd_transform u_xf (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_pair (r_pair),
        .i_point(s_in.data),
        .o_vec  (vec)
    );

    // Prep stage: magnitudes, scaled numerators, rounding offset, signs, zero-w flag.
    logic [ptpd_pkg::DivW-1:0]  r_num [3];
    logic [ptpd_pkg::SumW-2:0]  r_den;
    logic [2:0]                 r_neg;
    logic                       r_wz;
    logic [ptpd_pkg::SumW-1:0]  n_wmag;
    ptpd_pkg::t_sum             n_c [3];

    always_comb begin
        n_wmag = vec.w[ptpd_pkg::SumW-1] ? ptpd_pkg::SumW'(-vec.w) : vec.w;
        n_c[0] = vec.x;
        n_c[1] = vec.y;
        n_c[2] = vec.z;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den <= (vec.w == '0) ? (ptpd_pkg::SumW-1)'(1) : n_wmag[ptpd_pkg::SumW-2:0];
            r_wz  <= (vec.w == '0);
            for (int k = 0; k < 3; k++) begin
                r_neg[k] <= n_c[k][ptpd_pkg::SumW-1] ^ vec.w[ptpd_pkg::SumW-1];
                r_num[k] <= ({(ptpd_pkg::DivW-ptpd_pkg::SumW)'(0),
                              (n_c[k][ptpd_pkg::SumW-1] ? ptpd_pkg::SumW'(-n_c[k])
                                                        : n_c[k])} << 16)
                          + ptpd_pkg::DivW'(n_wmag >> 1);
            end
        end
    end

    logic [ptpd_pkg::QuotW-1:0] quot [3];
    for (genvar k = 0; k < 3; k++) begin : g_div
        ptpd_divider u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_num[k]),
            .i_den (r_den),
            .o_quot(quot[k])
        );
    end

    // Sign and zero flag travel alongside the divider.
    logic [3:0] r_side [DivStages];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= {r_neg, r_wz};
            for (int s = 1; s < int'(DivStages); s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // Full-width quotient, signed and saturated to the 32-bit range here; zeroed when w is zero.
    ptpd_pkg::t_result n_res;
    logic [3:0] side;
    always_comb begin
        side = r_side[DivStages-1];
        for (int k = 0; k < 3; k++) begin
            logic [ptpd_pkg::CoordW-1:0] v;
            if (side[k+1]) begin
                v = (quot[k] >= ptpd_pkg::QuotW'(33'h0_8000_0000)) ? 32'h8000_0000
                    : ptpd_pkg::CoordW'(-quot[k]);
            end else begin
                v = (quot[k] > ptpd_pkg::QuotW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                    : quot[k][ptpd_pkg::CoordW-1:0];
            end
            if (side[0]) begin
                v = '0;
            end
            case (k)
                0:       n_res.x = v;
                1:       n_res.y = v;
                default: n_res.z = v;
            endcase
        end
        n_res.w_zero = side[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[Lat-2:0], s_in.valid};
            end
            if (r_out_vld && !m_out.ready) begin
                if (en && r_vld[Lat-1]) begin
                    r_skid_vld <= 1'b1;
                end
            end else begin
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= en && r_vld[Lat-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_vld && !m_out.ready) begin
            if (en && r_vld[Lat-1]) begin
                r_skid <= n_res;
            end
        end else if (r_skid_vld) begin
            r_out <= r_skid;
        end else begin
            r_out <= n_res;
        end
    end

    assign m_out.valid = r_out_vld;
    assign m_out.data  = r_out;
endmodule
`default_nettype wire

FILE: rtl/ptpd_checker.sv
// Checker: port-level assertions for the point transform block, bound to the top level.
`default_nettype none
module ptpd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input ptpd_pkg::t_result   out_data
);
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.w_zero |-> out_data.x == '0 && out_data.y == '0
                                         && out_data.z == '0)
        else $error("w_zero result with nonzero coordinates");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ready |=> in_ready)
        else $error("input blocked while output drains");
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");
endmodule

bind point_transform_perspective_divide_top ptpd_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .in_ready (s_in.ready),
    .out_valid(m_out.valid),
    .out_ready(m_out.ready),
    .out_data (m_out.data)
);
`default_nettype wire
